// ===== design/mlbc_pkg.sv =====
package mlbc_pkg;

    // number of LED channels and the bits shown on the result
    localparam int LED_COUNT = 2;
    localparam int OUT_BITS  = 2;

    localparam int LED_IDX_W = 4;
    localparam int TIME_W    = 16;
    localparam int ELAPSED_W = 17;

    localparam logic [TIME_W-1:0]    FOREVER_COUNT = '1;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_ON    = 2'd1,
        CMD_OFF   = 2'd2,
        CMD_BLINK = 2'd3
    } cmd_t;

    // command as seen by every LED channel
    typedef struct packed {
        cmd_t              cmd;
        logic [TIME_W-1:0] on_time;
        logic [TIME_W-1:0] off_time;
        logic [TIME_W-1:0] repeat_count;
    } mlbc_op_t;

    // per-channel status after the item is applied
    typedef struct packed {
        logic level;
        logic running;
    } mlbc_led_stat_t;

endpackage

// ===== design/multi_led_blink_controller_top.sv =====
// channel  | direction | payload
// ---------+-----------+---------------------------------------------------
// s_       | in        | cmd, led, all_leds, on_time, off_time, repeat_count
// m_       | out       | led_levels, blinking_mask (one item per input item)
//
// One item per cycle sustained while m_ready is high. An accepted item goes
// into the input register; when it advances, the LED channels update and the
// result register loads the result, which then shows as valid.
// Reset (aresetn low, synchronous) darkens every LED, stops all blinking and
// empties both registers. A stall on m_ready holds the result; the input
// register still takes one more item, then s_ready drops.
module multi_led_blink_controller_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_cmd,
    input  logic [mlbc_pkg::LED_IDX_W-1:0]    s_led,
    input  logic                              s_all_leds,
    input  logic [mlbc_pkg::TIME_W-1:0]       s_on_time,
    input  logic [mlbc_pkg::TIME_W-1:0]       s_off_time,
    input  logic [mlbc_pkg::TIME_W-1:0]       s_repeat_count,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mlbc_pkg::OUT_BITS-1:0]     m_led_levels,
    output logic [mlbc_pkg::OUT_BITS-1:0]     m_blinking_mask
);

    logic                               in_valid_reg;
    mlbc_pkg::mlbc_op_t                 op_reg, op_next;
    logic [mlbc_pkg::LED_IDX_W-1:0]     led_reg;
    logic                               all_reg;
    logic                               out_valid_reg;
    logic [mlbc_pkg::OUT_BITS-1:0]      levels_reg, levels_next;
    logic [mlbc_pkg::OUT_BITS-1:0]      mask_reg,   mask_next;
    logic                               advance;
    logic                               accept;
    mlbc_pkg::mlbc_led_stat_t           stat [mlbc_pkg::LED_COUNT];
    logic [mlbc_pkg::LED_COUNT-1:0]     sel;

    // handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    assign op_next.cmd          = mlbc_pkg::cmd_t'(s_cmd);
    assign op_next.on_time      = s_on_time;
    assign op_next.off_time     = s_off_time;
    assign op_next.repeat_count = s_repeat_count;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= op_next;
            led_reg <= s_led;
            all_reg <= s_all_leds;
        end
    end

    // LED channels
    for (genvar i = 0; i < mlbc_pkg::LED_COUNT; i++) begin : g_led
        // all_leds applies to on and off only
        assign sel[i] = (led_reg == mlbc_pkg::LED_IDX_W'(i))
                        || (all_reg && (op_reg.cmd != mlbc_pkg::CMD_BLINK));

        mlbc_led_unit u_led (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step      (advance),
            .op        (op_reg),
            .sel       (sel[i]),
            .stat_next (stat[i])
        );
    end

    // result bits for the shown LEDs
    for (genvar j = 0; j < mlbc_pkg::OUT_BITS; j++) begin : g_out
        if (j < mlbc_pkg::LED_COUNT) begin : g_used
            assign levels_next[j] = stat[j].level;
            assign mask_next[j]   = stat[j].running;
        end else begin : g_unused
            assign levels_next[j] = 1'b0;
            assign mask_next[j]   = 1'b0;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            levels_reg <= levels_next;
            mask_reg   <= mask_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_led_levels    = levels_reg;
    assign m_blinking_mask = mask_reg;

    // a result appears only after an item left the input register
    a_result_from_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result valid without an advanced item");

    // an empty input register always takes an item
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but not ready");

    // a stalled result keeps the input register from advancing
    a_no_advance_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !advance)
        else $error("advance while result stalled");

endmodule

// ===== design/mlbc_led_unit.sv =====
module mlbc_led_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  mlbc_pkg::mlbc_op_t         op,
    input  logic                       sel,
    output mlbc_pkg::mlbc_led_stat_t   stat_next
);

    logic                           level_reg,   level_next;
    logic                           phase_reg,   phase_next;
    logic                           running_reg, running_next;
    logic [mlbc_pkg::TIME_W-1:0]    lit_reg,     lit_next;
    logic [mlbc_pkg::TIME_W-1:0]    dark_reg,    dark_next;
    logic [mlbc_pkg::ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [mlbc_pkg::TIME_W-1:0]    remain_reg,  remain_next;

    logic                        same_blink;
    logic [mlbc_pkg::TIME_W-1:0] remain_dec;

    assign same_blink = (lit_reg == op.on_time) && (dark_reg == op.off_time)
                        && (remain_reg == op.repeat_count);

    // count down unless forever or already exhausted
    assign remain_dec = ((remain_reg != mlbc_pkg::FOREVER_COUNT) && (remain_reg != '0))
                        ? remain_reg - 1'b1 : remain_reg;

    // next state for one item
    always_comb begin
        level_next   = level_reg;
        phase_next   = phase_reg;
        running_next = running_reg;
        lit_next     = lit_reg;
        dark_next    = dark_reg;
        elapsed_next = elapsed_reg;
        remain_next  = remain_reg;
        unique case (op.cmd)
            mlbc_pkg::CMD_TICK: begin
                if (running_reg) begin
                    if (phase_reg) begin
                        if (elapsed_reg >= {1'b0, lit_reg}) begin
                            phase_next   = 1'b0;
                            elapsed_next = '0;
                        end
                    end else if (elapsed_reg >= {1'b0, dark_reg}) begin
                        remain_next = remain_dec;
                        if (remain_dec == '0) begin
                            running_next = 1'b0;
                        end else begin
                            phase_next   = 1'b1;
                            elapsed_next = '0;
                        end
                    end
                    // saturating phase timer
                    if (elapsed_next != mlbc_pkg::ELAPSED_MAX) begin
                        elapsed_next = elapsed_next + 1'b1;
                    end
                    level_next = phase_next;
                end
            end
            mlbc_pkg::CMD_ON, mlbc_pkg::CMD_OFF: begin
                if (sel) begin
                    running_next = 1'b0;
                    level_next   = (op.cmd == mlbc_pkg::CMD_ON);
                end
            end
            mlbc_pkg::CMD_BLINK: begin
                if (sel && !same_blink) begin
                    lit_next     = op.on_time;
                    dark_next    = op.off_time;
                    elapsed_next = '0;
                    // zero repeats only refreshes the periods and restarts the phase timer
                    if (op.repeat_count != '0) begin
                        remain_next  = op.repeat_count;
                        running_next = 1'b1;
                        phase_next   = 1'b1;
                        level_next   = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg   <= 1'b0;
            phase_reg   <= 1'b0;
            running_reg <= 1'b0;
            lit_reg     <= '0;
            dark_reg    <= '0;
            elapsed_reg <= '0;
            remain_reg  <= '0;
        end else if (step) begin
            level_reg   <= level_next;
            phase_reg   <= phase_next;
            running_reg <= running_next;
            lit_reg     <= lit_next;
            dark_reg    <= dark_next;
            elapsed_reg <= elapsed_next;
            remain_reg  <= remain_next;
        end
    end

    assign stat_next.level   = level_next;
    assign stat_next.running = running_next;

endmodule

// ===== tb/tb.sv =====
module tb;
    import mlbc_pkg::*;

    localparam int ITEM_TARGET = 1700;
    localparam int QUIET_FROM  = 1500;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DIR_ROWS    = 23;

    // expected status of the two visible LEDs after one item
    typedef struct packed {
        logic [OUT_BITS-1:0] levels;
        logic [OUT_BITS-1:0] mask;
    } led_status_t;

    // one row of the directed table; chk marks a typed-in expectation
    typedef struct packed {
        cmd_t              cmd;
        logic [3:0]        led;
        logic              all_leds;
        logic [TIME_W-1:0] on_t;
        logic [TIME_W-1:0] off_t;
        logic [TIME_W-1:0] reps;
        logic              chk;
        logic [1:0]        lvl;
        logic [1:0]        msk;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // out of reset, then fixed levels and an index past the last LED
        '{CMD_TICK,  4'd0,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 2'b00, 2'b00},
        '{CMD_ON,    4'd0,  1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1, 2'b11, 2'b00},
        '{CMD_OFF,   4'd1,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 2'b01, 2'b00},
        '{CMD_ON,    4'd15, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 2'b01, 2'b00},
        '{CMD_OFF,   4'd0,  1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1, 2'b00, 2'b00},
        // a short blink sequence on LED 0, followed by ticks
        '{CMD_BLINK, 4'd0,  1'b0, 16'd2,    16'd1,    16'd2,    1'b1, 2'b01, 2'b01},
        '{CMD_TICK,  4'd0,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 2'b00, 2'b00},
        '{CMD_TICK,  4'd0,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 2'b00, 2'b00},
        '{CMD_TICK,  4'd0,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 2'b00, 2'b00},
        '{CMD_TICK,  4'd0,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 2'b00, 2'b00},
        '{CMD_TICK,  4'd0,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 2'b00, 2'b00},
        // zero-length periods on LED 1
        '{CMD_BLINK, 4'd1,  1'b0, 16'd0,    16'd0,    16'd1,    1'b0, 2'b00, 2'b00},
        '{CMD_TICK,  4'd0,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 2'b00, 2'b00},
        '{CMD_TICK,  4'd0,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 2'b00, 2'b00},
        // endless blink, off, then the same blink again is ignored
        '{CMD_BLINK, 4'd0,  1'b0, 16'd3,    16'd3,    16'hFFFF, 1'b0, 2'b00, 2'b00},
        '{CMD_OFF,   4'd0,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 2'b00, 2'b00},
        '{CMD_BLINK, 4'd0,  1'b0, 16'd3,    16'd3,    16'hFFFF, 1'b0, 2'b00, 2'b00},
        // blink ignores the all flag; out of range index does nothing
        '{CMD_BLINK, 4'd9,  1'b1, 16'd1,    16'd1,    16'd1,    1'b0, 2'b00, 2'b00},
        '{CMD_BLINK, 4'd1,  1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 2'b00, 2'b00},
        '{CMD_TICK,  4'd15, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 2'b00, 2'b00},
        // zero repeats only reloads the periods and restarts the phase timer
        '{CMD_BLINK, 4'd0,  1'b0, 16'd1,    16'd1,    16'd0,    1'b0, 2'b00, 2'b00},
        '{CMD_ON,    4'd1,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 2'b00, 2'b00},
        '{CMD_OFF,   4'd0,  1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1, 2'b00, 2'b00}
    };

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_cmd = 2'b00;
    logic [LED_IDX_W-1:0]   s_led = '0;
    logic                   s_all_leds = 1'b0;
    logic [TIME_W-1:0]      s_on_time = '0;
    logic [TIME_W-1:0]      s_off_time = '0;
    logic [TIME_W-1:0]      s_repeat_count = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_BITS-1:0]    m_led_levels;
    logic [OUT_BITS-1:0]    m_blinking_mask;

    // typed-in expectation riding along with the item on the input side
    logic                   row_chk = 1'b0;
    logic [1:0]             row_lvl = '0;
    logic [1:0]             row_msk = '0;

    // predicted LED state
    logic                   drv_lvl     [LED_COUNT];
    logic                   ph_lit      [LED_COUNT];
    logic                   blinking    [LED_COUNT];
    logic [TIME_W-1:0]      lit_len     [LED_COUNT];
    logic [TIME_W-1:0]      dark_len    [LED_COUNT];
    logic [ELAPSED_W-1:0]   age         [LED_COUNT];
    logic [TIME_W-1:0]      cycles_left [LED_COUNT];

    led_status_t            pending_status [$];
    led_status_t            got_pred;
    led_status_t            head;

    // last blink settings sent per LED, to resend identical commands
    logic [TIME_W-1:0]      last_on   [LED_COUNT];
    logic [TIME_W-1:0]      last_off  [LED_COUNT];
    logic [TIME_W-1:0]      last_reps [LED_COUNT];

    int                     err_cnt = 0;
    int                     n_live = 0;
    int                     cycle_cnt = 0;
    int                     gap_pct = 0;
    int                     stall_pct = 0;
    bit                     drained_mid = 0;

    multi_led_blink_controller_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_led           (s_led),
        .s_all_leds      (s_all_leds),
        .s_on_time       (s_on_time),
        .s_off_time      (s_off_time),
        .s_repeat_count  (s_repeat_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_led_levels    (m_led_levels),
        .m_blinking_mask (m_blinking_mask)
    );

    always #10 aclk = ~aclk;

    // applies one item to the predicted state and returns the visible status
    function automatic led_status_t advance_leds(input cmd_t c, input logic [3:0] idx,
                                                 input logic all_f,
                                                 input logic [TIME_W-1:0] on_t,
                                                 input logic [TIME_W-1:0] off_t,
                                                 input logic [TIME_W-1:0] reps);
        led_status_t st;
        case (c)
            CMD_TICK: begin
                for (int i = 0; i < LED_COUNT; i++) begin
                    if (blinking[i]) begin
                        if (ph_lit[i]) begin
                            if (age[i] >= {1'b0, lit_len[i]}) begin
                                ph_lit[i] = 1'b0;
                                age[i] = '0;
                            end
                        end else if (age[i] >= {1'b0, dark_len[i]}) begin
                            if (cycles_left[i] != FOREVER_COUNT && cycles_left[i] != '0)
                                cycles_left[i] = cycles_left[i] - 1'b1;
                            if (cycles_left[i] == '0) begin
                                blinking[i] = 1'b0;
                            end else begin
                                ph_lit[i] = 1'b1;
                                age[i] = '0;
                            end
                        end
                        if (age[i] != ELAPSED_MAX)
                            age[i] = age[i] + 1'b1;
                        drv_lvl[i] = ph_lit[i];
                    end
                end
            end
            CMD_ON, CMD_OFF: begin
                for (int i = 0; i < LED_COUNT; i++) begin
                    if (all_f || idx == i) begin
                        blinking[i] = 1'b0;
                        drv_lvl[i] = (c == CMD_ON);
                    end
                end
            end
            default: begin
                if (idx < LED_COUNT && !(lit_len[idx] == on_t && dark_len[idx] == off_t &&
                                         cycles_left[idx] == reps)) begin
                    lit_len[idx] = on_t;
                    dark_len[idx] = off_t;
                    age[idx] = '0;
                    if (reps != '0) begin
                        cycles_left[idx] = reps;
                        blinking[idx] = 1'b1;
                        ph_lit[idx] = 1'b1;
                        drv_lvl[idx] = 1'b1;
                    end
                end
            end
        endcase
        st = '0;
        for (int i = 0; i < LED_COUNT && i < OUT_BITS; i++) begin
            st.levels[i] = drv_lvl[i];
            st.mask[i] = blinking[i];
        end
        return st;
    endfunction

    // prediction on input accept, comparison on result accept
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            got_pred = advance_leds(cmd_t'(s_cmd), s_led, s_all_leds, s_on_time,
                                    s_off_time, s_repeat_count);
            if (row_chk)
                got_pred = {row_lvl, row_msk};
            pending_status.push_back(got_pred);
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                $error("result with nothing expected: led_levels %0h blinking_mask %0h",
                       m_led_levels, m_blinking_mask);
                err_cnt++;
            end else begin
                head = pending_status.pop_front();
                if (head.levels !== m_led_levels) begin
                    $error("led_levels: expected %0h, got %0h", head.levels, m_led_levels);
                    err_cnt++;
                end
                if (head.mask !== m_blinking_mask) begin
                    $error("blinking_mask: expected %0h, got %0h", head.mask, m_blinking_mask);
                    err_cnt++;
                end
            end
        end
    end

    // result side back-pressure in random bursts
    always begin
        @(posedge aclk);
        if (aresetn && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        m_ready <= 1'b1;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_item(input cmd_t c, input logic [3:0] idx, input logic all_f,
                             input logic [TIME_W-1:0] on_t, input logic [TIME_W-1:0] off_t,
                             input logic [TIME_W-1:0] reps, input logic chk = 1'b0,
                             input logic [1:0] lvl = 2'b00, input logic [1:0] msk = 2'b00);
        s_valid        <= 1'b1;
        s_cmd          <= c;
        s_led          <= idx;
        s_all_leds     <= all_f;
        s_on_time      <= on_t;
        s_off_time     <= off_t;
        s_repeat_count <= reps;
        row_chk        <= chk;
        row_lvl        <= lvl;
        row_msk        <= msk;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // items aimed at a missing LED do not count
        if (c == CMD_TICK || (c != CMD_BLINK && all_f) || idx < LED_COUNT)
            n_live++;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    // sender holds off until every outstanding result is back
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_status.size() != 0);
    endtask

    function automatic int pick_rate();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_period();
        if ($urandom_range(0, 9) == 0)
            return TIME_W'($urandom);
        return TIME_W'($urandom_range(0, 6));
    endfunction

    // a blink command followed by ticks, with a few on/off commands mixed in
    task automatic blink_run();
        logic [3:0]        idx;
        logic [TIME_W-1:0] on_t;
        logic [TIME_W-1:0] off_t;
        logic [TIME_W-1:0] reps;
        cmd_t              c;
        if ($urandom_range(0, 9) == 0)
            idx = 4'($urandom_range(LED_COUNT, 15));
        else
            idx = 4'($urandom_range(0, LED_COUNT - 1));
        if (idx < LED_COUNT && $urandom_range(0, 9) == 0) begin
            on_t = last_on[idx];
            off_t = last_off[idx];
            reps = last_reps[idx];
        end else begin
            on_t = pick_period();
            off_t = pick_period();
            case ($urandom_range(0, 9))
                0:       reps = '0;
                1:       reps = FOREVER_COUNT;
                2:       reps = TIME_W'($urandom);
                default: reps = TIME_W'($urandom_range(1, 4));
            endcase
        end
        if (idx < LED_COUNT) begin
            last_on[idx] = on_t;
            last_off[idx] = off_t;
            last_reps[idx] = reps;
        end
        send_item(CMD_BLINK, idx, 1'($urandom), on_t, off_t, reps);
        repeat ($urandom_range(1, 24)) begin
            if ($urandom_range(0, 9) == 0) begin
                c = $urandom_range(0, 1) ? CMD_ON : CMD_OFF;
                send_item(c, 4'($urandom_range(0, 2)), ($urandom_range(0, 3) == 0),
                          TIME_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
            end else begin
                send_item(CMD_TICK, 4'($urandom), 1'($urandom), TIME_W'($urandom),
                          TIME_W'($urandom), TIME_W'($urandom));
            end
        end
    endtask

    // fully random items
    task automatic noise_run();
        repeat ($urandom_range(1, 6))
            send_item(cmd_t'($urandom_range(0, 3)), 4'($urandom), 1'($urandom),
                      TIME_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
    endtask

    // stimulus
    initial begin
        for (int i = 0; i < LED_COUNT; i++) begin
            drv_lvl[i] = 1'b0;
            ph_lit[i] = 1'b0;
            blinking[i] = 1'b0;
            lit_len[i] = '0;
            dark_len[i] = '0;
            age[i] = '0;
            cycles_left[i] = '0;
            last_on[i] = '0;
            last_off[i] = '0;
            last_reps[i] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, no idling
        for (int r = 0; r < DIR_ROWS; r++)
            send_item(DIRECTED[r].cmd, DIRECTED[r].led, DIRECTED[r].all_leds,
                      DIRECTED[r].on_t, DIRECTED[r].off_t, DIRECTED[r].reps,
                      DIRECTED[r].chk, DIRECTED[r].lvl, DIRECTED[r].msk);
        hold_until_drained();

        // random sequences with changing idle rates, quiet toward the end
        while (n_live < ITEM_TARGET) begin
            if (n_live >= QUIET_FROM) begin
                gap_pct = 0;
                stall_pct = 0;
            end else begin
                gap_pct = pick_rate();
                stall_pct = pick_rate();
            end
            if (!drained_mid && n_live >= ITEM_TARGET / 2) begin
                hold_until_drained();
                drained_mid = 1;
            end
            if ($urandom_range(0, 9) < 7)
                blink_run();
            else
                noise_run();
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_status.size() != 0);
        repeat (4) @(posedge aclk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
